// ===== rtl/stop_and_wait_transfer_sender_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the stop-and-wait sender
// Shared property forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef STOP_AND_WAIT_TRANSFER_SENDER_CORE_MACROS_SVH
`define STOP_AND_WAIT_TRANSFER_SENDER_CORE_MACROS_SVH

// Concurrent assertion on a clock, disabled while reset is asserted.
`define SWTS_ASSERT_CLK(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("swts assertion failed");

// Same check on the block clock and reset.
`define SWTS_ASSERT(lbl, prop) \
    `SWTS_ASSERT_CLK(lbl, aclk, aresetn, prop)

`endif

// ===== rtl/swts_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swts_pkg
// Types, codes and constants shared by the stop-and-wait sender modules.
// ----------------------------------------------------------------------------
package swts_pkg;

    localparam int unsigned MAX_PAYLOAD_DEF = 1478;
    localparam int unsigned LEN_W           = 11;

    // Command codes
    localparam logic [2:0] CMD_START   = 3'd0;
    localparam logic [2:0] CMD_DGRAM   = 3'd1;
    localparam logic [2:0] CMD_TIMEOUT = 3'd2;
    localparam logic [2:0] CMD_CHUNK   = 3'd3;
    localparam logic [2:0] CMD_EOF     = 3'd4;

    // PDU type codes
    localparam logic [2:0] T_NONE  = 3'd0;
    localparam logic [2:0] T_HELLO = 3'd1;
    localparam logic [2:0] T_WRQ   = 3'd2;
    localparam logic [2:0] T_DATA  = 3'd3;
    localparam logic [7:0] T_ACK   = 8'd4;
    localparam logic [2:0] T_FIN   = 3'd5;

    // Status codes
    localparam logic [2:0] ST_BUSY     = 3'd0;
    localparam logic [2:0] ST_DONE     = 3'd1;
    localparam logic [2:0] ST_REJECTED = 3'd2;
    localparam logic [2:0] ST_RETRIES  = 3'd3;
    localparam logic [2:0] ST_BAD_LEN  = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] CFG_RETRY_LIMIT = 2'd0;
    localparam logic [1:0] CFG_CRED_LENGTH = 2'd1;
    localparam logic [1:0] CFG_NAME_LENGTH = 2'd2;

    localparam logic [3:0] RETRY_LIMIT_RST = 4'd5;

    // Classified event handed from the front to the back
    typedef struct packed {
        logic [2:0]       cmd;
        logic             from_srv;
        logic             rx_short;   // shorter than a header
        logic             rx_long;    // header plus payload
        logic             not_ack;
        logic             seq_hi;     // upper seq bits nonzero
        logic             seq_lsb;
        logic [LEN_W-1:0] chunk_len;  // already saturated
    } evt_t;

endpackage

// ===== rtl/swts_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swts_front
// Accepts input transactions and classifies them into compact events.
// ----------------------------------------------------------------------------
module swts_front #(
    parameter int unsigned MAX_PAYLOAD = swts_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [2:0]                 s_cmd,
    input  logic [7:0]                 s_rx_type,
    input  logic [7:0]                 s_rx_seq,
    input  logic [10:0]                s_rx_len,
    input  logic                       s_rx_from_server,
    input  logic [10:0]                s_chunk_len,
    input  logic                       q_full,
    output logic                       q_push,
    output swts_pkg::evt_t             q_evt
);

    localparam logic [10:0] MAX_LEN = 11'(MAX_PAYLOAD);

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    always_comb begin
        q_evt.cmd       = s_cmd;
        q_evt.from_srv  = s_rx_from_server;
        q_evt.rx_short  = (s_rx_len < 11'd2);
        q_evt.rx_long   = (s_rx_len > 11'd2);
        q_evt.not_ack   = (s_rx_type != swts_pkg::T_ACK);
        q_evt.seq_hi    = |s_rx_seq[7:1];
        q_evt.seq_lsb   = s_rx_seq[0];
        // clamp oversized chunks
        q_evt.chunk_len = (s_chunk_len > MAX_LEN) ? MAX_LEN : s_chunk_len;
    end

endmodule

// ===== rtl/swts_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swts_queue
// Two-entry event queue between the front and the back.
// ----------------------------------------------------------------------------
module swts_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  swts_pkg::evt_t push_evt,
    output logic           full,
    input  logic           pop,
    output logic           not_empty,
    output swts_pkg::evt_t head_evt
);

    swts_pkg::evt_t entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head_evt  = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_evt;
        end
    end

endmodule

// ===== rtl/swts_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swts_back
// Transfer state machine: executes queued events and registers the result.
// ----------------------------------------------------------------------------
module swts_back #(
    parameter int unsigned MAX_PAYLOAD = swts_pkg::MAX_PAYLOAD_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           cfg_wr_en,
    input  logic [1:0]     cfg_index,
    input  logic [10:0]    cfg_data,
    input  logic           q_not_empty,
    input  swts_pkg::evt_t q_evt,
    output logic           q_pop,
    output logic           m_valid,
    input  logic           m_ready,
    output logic           m_tx_valid,
    output logic [2:0]     m_tx_type,
    output logic           m_tx_seq,
    output logic [10:0]    m_tx_len,
    output logic           m_want_chunk,
    output logic [3:0]     m_attempt,
    output logic [2:0]     m_status
);

    localparam logic [10:0] MAX_LEN = 11'(MAX_PAYLOAD);

    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_HELLO = 3'd1;
    localparam logic [2:0] PH_WRQ   = 3'd2;
    localparam logic [2:0] PH_NEED  = 3'd3;
    localparam logic [2:0] PH_DATA  = 3'd4;
    localparam logic [2:0] PH_FIN   = 3'd5;

    logic [3:0]  retry_limit_reg;
    logic [10:0] cred_length_reg;
    logic [3:0]  name_length_reg;

    logic [2:0]  phase_reg, phase_next;
    logic        send_seq_reg, send_seq_next;
    logic [3:0]  retry_count_reg, retry_count_next;
    logic [2:0]  pending_type_reg, pending_type_next;
    logic [10:0] pending_len_reg, pending_len_next;
    logic        data_sent_reg, data_sent_next;
    logic        eof_seen_reg, eof_seen_next;

    logic        out_valid_reg;
    logic        tx_valid_reg, tx_next;
    logic [2:0]  tx_type_reg;
    logic        tx_seq_reg;
    logic [10:0] tx_len_reg;
    logic        want_chunk_reg;
    logic [3:0]  attempt_reg;
    logic [2:0]  status_reg, status_next;

    logic        waiting;
    logic [3:0]  retry_inc;
    logic [3:0]  retry_lim;
    logic        retry_out;
    logic [10:0] name_plus1;
    logic        name_bad;

    assign q_pop = q_not_empty && (!out_valid_reg || m_ready);

    always_comb begin
        waiting    = (phase_reg == PH_HELLO) || (phase_reg == PH_WRQ) ||
                     (phase_reg == PH_DATA)  || (phase_reg == PH_FIN);
        retry_inc  = (retry_count_reg == 4'd15) ? retry_count_reg : retry_count_reg + 4'd1;
        retry_lim  = (retry_limit_reg == 4'd0) ? 4'd1 : retry_limit_reg;
        retry_out  = (retry_inc >= retry_lim);
        name_plus1 = {7'd0, name_length_reg} + 11'd1;
        name_bad   = (name_length_reg < 4'd4) || (name_length_reg > 4'd10);
    end

    always_comb begin
        phase_next        = phase_reg;
        send_seq_next     = send_seq_reg;
        retry_count_next  = retry_count_reg;
        pending_type_next = pending_type_reg;
        pending_len_next  = pending_len_reg;
        data_sent_next    = data_sent_reg;
        eof_seen_next     = eof_seen_reg;
        tx_next           = 1'b0;
        status_next       = swts_pkg::ST_BUSY;

        if (q_evt.cmd == swts_pkg::CMD_START && phase_reg == PH_IDLE) begin
            if (cred_length_reg == 11'd0 || cred_length_reg > MAX_LEN) begin
                status_next = swts_pkg::ST_BAD_LEN;
            end else begin
                send_seq_next     = 1'b0;
                data_sent_next    = 1'b0;
                eof_seen_next     = 1'b0;
                pending_type_next = swts_pkg::T_HELLO;
                pending_len_next  = cred_length_reg;
                retry_count_next  = 4'd0;
                phase_next        = PH_HELLO;
                tx_next           = 1'b1;
            end
        end else if ((q_evt.cmd == swts_pkg::CMD_TIMEOUT && waiting) ||
                     (q_evt.cmd == swts_pkg::CMD_DGRAM && waiting && q_evt.from_srv &&
                      (q_evt.rx_short || q_evt.not_ack))) begin
            // count a retry, give up at the limit
            retry_count_next = retry_inc;
            if (retry_out) begin
                status_next = swts_pkg::ST_RETRIES;
                phase_next  = PH_IDLE;
            end else begin
                tx_next = 1'b1;
            end
        end else if (q_evt.cmd == swts_pkg::CMD_DGRAM && waiting) begin
            if (!q_evt.from_srv || q_evt.seq_hi || (q_evt.seq_lsb != send_seq_reg)) begin
                tx_next = 1'b1;   // resend, no retry counted
            end else if (q_evt.rx_long) begin
                status_next = swts_pkg::ST_REJECTED;
                phase_next  = PH_IDLE;
            end else begin
                retry_count_next = 4'd0;
                unique case (phase_reg)
                    PH_HELLO: begin
                        if (name_bad) begin
                            status_next = swts_pkg::ST_BAD_LEN;
                            phase_next  = PH_IDLE;
                        end else begin
                            send_seq_next     = 1'b1;
                            pending_type_next = swts_pkg::T_WRQ;
                            pending_len_next  = name_plus1;
                            phase_next        = PH_WRQ;
                            tx_next           = 1'b1;
                        end
                    end
                    PH_WRQ: begin
                        send_seq_next = 1'b0;
                        phase_next    = PH_NEED;
                    end
                    PH_DATA: begin
                        data_sent_next = 1'b1;
                        send_seq_next  = !send_seq_reg;
                        if (eof_seen_reg) begin
                            pending_type_next = swts_pkg::T_FIN;
                            pending_len_next  = name_plus1;
                            phase_next        = PH_FIN;
                            tx_next           = 1'b1;
                        end else begin
                            phase_next = PH_NEED;
                        end
                    end
                    default: begin
                        status_next = swts_pkg::ST_DONE;
                        phase_next  = PH_IDLE;
                    end
                endcase
            end
        end else if (q_evt.cmd == swts_pkg::CMD_CHUNK && phase_reg == PH_NEED) begin
            if (q_evt.chunk_len != 11'd0) begin
                pending_type_next = swts_pkg::T_DATA;
                pending_len_next  = q_evt.chunk_len;
                retry_count_next  = 4'd0;
                phase_next        = PH_DATA;
                tx_next           = 1'b1;
            end
        end else if (q_evt.cmd == swts_pkg::CMD_EOF && phase_reg == PH_NEED) begin
            eof_seen_next    = 1'b1;
            retry_count_next = 4'd0;
            tx_next          = 1'b1;
            if (!data_sent_reg) begin
                // empty file: one empty DATA
                pending_type_next = swts_pkg::T_DATA;
                pending_len_next  = 11'd0;
                phase_next        = PH_DATA;
            end else begin
                pending_type_next = swts_pkg::T_FIN;
                pending_len_next  = name_plus1;
                phase_next        = PH_FIN;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            retry_limit_reg <= swts_pkg::RETRY_LIMIT_RST;
            cred_length_reg <= 11'd0;
            name_length_reg <= 4'd0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                swts_pkg::CFG_RETRY_LIMIT: retry_limit_reg <= cfg_data[3:0];
                swts_pkg::CFG_CRED_LENGTH: cred_length_reg <= cfg_data;
                swts_pkg::CFG_NAME_LENGTH: name_length_reg <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_IDLE;
            send_seq_reg     <= 1'b0;
            retry_count_reg  <= 4'd0;
            pending_type_reg <= swts_pkg::T_NONE;
            pending_len_reg  <= 11'd0;
            data_sent_reg    <= 1'b0;
            eof_seen_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end else begin
            if (q_pop) begin
                phase_reg        <= phase_next;
                send_seq_reg     <= send_seq_next;
                retry_count_reg  <= retry_count_next;
                pending_type_reg <= pending_type_next;
                pending_len_reg  <= pending_len_next;
                data_sent_reg    <= data_sent_next;
                eof_seen_reg     <= eof_seen_next;
                out_valid_reg    <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, loaded with each executed event
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            tx_valid_reg   <= tx_next;
            tx_type_reg    <= tx_next ? pending_type_next : swts_pkg::T_NONE;
            tx_seq_reg     <= tx_next && send_seq_next;
            tx_len_reg     <= tx_next ? pending_len_next : 11'd0;
            want_chunk_reg <= (phase_next == PH_NEED);
            attempt_reg    <= retry_count_next;
            status_reg     <= status_next;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_tx_valid   = tx_valid_reg;
    assign m_tx_type    = tx_type_reg;
    assign m_tx_seq     = tx_seq_reg;
    assign m_tx_len     = tx_len_reg;
    assign m_want_chunk = want_chunk_reg;
    assign m_attempt    = attempt_reg;
    assign m_status     = status_reg;

endmodule

// ===== rtl/stop_and_wait_transfer_sender_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stop_and_wait_transfer_sender_core
// Alternating-bit stop-and-wait sender: decides which PDU header to send.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel carries events (start, datagram, timeout, chunk, end of file)
//   with the received header fields; m_* channel returns one result per event:
//   the PDU header to send (if any), the chunk request flag, retry count and
//   status. cfg_wr_en/cfg_index/cfg_data write retry_limit, cred_length and
//   name_length; write them only while no transaction is outstanding.
// Timing:
//   An accepted event waits in the queue, is executed once it is at the head
//   and the result register is free or being read, and its result is registered.
//   One event per cycle sustained while m_ready stays high.
// Reset (aresetn low, synchronous): idle phase, empty event queue, no result
//   pending, registers back to their defaults (retry_limit 5).
// Stall: when m_ready is low the result holds; the two-entry queue keeps
//   taking events until it fills, then s_ready drops.
// ----------------------------------------------------------------------------
module stop_and_wait_transfer_sender_core #(
    parameter int unsigned MAX_PAYLOAD = swts_pkg::MAX_PAYLOAD_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [10:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_cmd,
    input  logic [7:0]  s_rx_type,
    input  logic [7:0]  s_rx_seq,
    input  logic [10:0] s_rx_len,
    input  logic        s_rx_from_server,
    input  logic [10:0] s_chunk_len,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_tx_valid,
    output logic [2:0]  m_tx_type,
    output logic        m_tx_seq,
    output logic [10:0] m_tx_len,
    output logic        m_want_chunk,
    output logic [3:0]  m_attempt,
    output logic [2:0]  m_status
);

    logic           q_full;
    logic           q_push;
    logic           q_pop;
    logic           q_not_empty;
    swts_pkg::evt_t push_evt;
    swts_pkg::evt_t head_evt;

    swts_front #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_front (
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_cmd           (s_cmd),
        .s_rx_type       (s_rx_type),
        .s_rx_seq        (s_rx_seq),
        .s_rx_len        (s_rx_len),
        .s_rx_from_server(s_rx_from_server),
        .s_chunk_len     (s_chunk_len),
        .q_full          (q_full),
        .q_push          (q_push),
        .q_evt           (push_evt)
    );

    swts_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_evt (push_evt),
        .full     (q_full),
        .pop      (q_pop),
        .not_empty(q_not_empty),
        .head_evt (head_evt)
    );

    swts_back #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .q_not_empty (q_not_empty),
        .q_evt       (head_evt),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_tx_valid  (m_tx_valid),
        .m_tx_type   (m_tx_type),
        .m_tx_seq    (m_tx_seq),
        .m_tx_len    (m_tx_len),
        .m_want_chunk(m_want_chunk),
        .m_attempt   (m_attempt),
        .m_status    (m_status)
    );

endmodule

// ===== rtl/swts_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swts_checker
// Port-level checks on the sender result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "stop_and_wait_transfer_sender_core_macros.svh"

module swts_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_tx_valid,
    input logic [2:0]  m_tx_type,
    input logic        m_tx_seq,
    input logic [10:0] m_tx_len,
    input logic        m_want_chunk,
    input logic [2:0]  m_status
);

    // a stalled result holds
    `SWTS_ASSERT(a_hold, (m_valid && !m_ready) |=> (m_valid && $stable(m_tx_type) && $stable(m_tx_len) && $stable(m_status)))

    // a header to send means the transfer is still running
    `SWTS_ASSERT(a_tx_busy, (m_valid && m_tx_valid) |-> (m_status == swts_pkg::ST_BUSY && m_tx_type != swts_pkg::T_NONE && !m_want_chunk))

    // no header: header fields read as zero
    `SWTS_ASSERT(a_no_tx_zero, (m_valid && !m_tx_valid) |-> (m_tx_type == swts_pkg::T_NONE && !m_tx_seq && m_tx_len == 11'd0))

    // HELLO always carries seq 0, WRQ seq 1
    `SWTS_ASSERT(a_setup_seq, (m_valid && m_tx_valid && (m_tx_type == swts_pkg::T_HELLO || m_tx_type == swts_pkg::T_WRQ)) |-> (m_tx_seq == (m_tx_type == swts_pkg::T_WRQ)))

endmodule

bind stop_and_wait_transfer_sender_core swts_checker u_swts_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_tx_valid  (m_tx_valid),
    .m_tx_type   (m_tx_type),
    .m_tx_seq    (m_tx_seq),
    .m_tx_len    (m_tx_len),
    .m_want_chunk(m_want_chunk),
    .m_status    (m_status)
);
